@@ hw/rtl/page_frame_allocator_resize_core_macros.svh @@
// ----------------------------------------------------------------------------
// page frame allocator assertion macros
// shared property forms for the allocator's concurrent checks
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_RESIZE_CORE_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_RESIZE_CORE_MACROS_SVH

// consequent checked in the same cycle
`define PFAR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PFAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pfar_pkg.sv @@
// ----------------------------------------------------------------------------
// pfar_pkg
// sizes, microcode encoding and control store of the page frame allocator
// ----------------------------------------------------------------------------
package pfar_pkg;

  localparam int MAX_FRAMES    = 64;
  localparam int MAX_PROCESSES = 16;
  localparam int MAX_PAGES     = 64;

  localparam int PAGE_SIZE_W   = 13;
  localparam int FRAME_COUNT_W = 7;
  localparam int BYTES_W       = 20;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 1;

  localparam int FRAME_W   = $clog2(MAX_FRAMES);
  localparam int SLOT_W    = $clog2(MAX_PROCESSES);
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int CNT_W     = 7;
  localparam int MAP_AW    = SLOT_W + PAGE_W;
  localparam int MAP_DEPTH = MAX_PROCESSES * MAX_PAGES;
  localparam int DIV_CNT_W = $clog2(BYTES_W + 1);
  localparam int STEP_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'b1;

  localparam logic [PAGE_SIZE_W-1:0]   PAGE_SIZE_RST   = PAGE_SIZE_W'(32);
  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = FRAME_COUNT_W'(64);
  localparam logic [FRAME_COUNT_W-1:0] FRAME_LIMIT     = FRAME_COUNT_W'(MAX_FRAMES);
  localparam logic [CNT_W-1:0]         PAGES_LIMIT     = CNT_W'(MAX_PAGES);
  localparam logic [DIV_CNT_W-1:0]     DIV_STEPS       = DIV_CNT_W'(BYTES_W);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLRNEED,
    OP_DIVSTEP,
    OP_SETNEED,
    OP_ADVANCE,
    OP_CLAIM,
    OP_OUTPUT,
    OP_RDMAP,
    OP_FREE
  } op_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_IS_REMOVE,
    COND_DIV_MORE,
    COND_HELD_GE_NEED,
    COND_HELD_LE_NEED,
    COND_HELD_FULL,
    COND_FRAME_BUSY,
    COND_FRAME_FREE,
    COND_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_input;
    logic is_remove;
    logic div_more;
    logic held_ge_need;
    logic held_le_need;
    logic held_full;
    logic frame_busy;
    logic frame_free;
    logic out_blocked;
  } flags_t;

  localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] ST_FUNC   = 4'd1;
  localparam logic [STEP_W-1:0] ST_DIV    = 4'd2;
  localparam logic [STEP_W-1:0] ST_NEED   = 4'd3;
  localparam logic [STEP_W-1:0] ST_CMP    = 4'd4;
  localparam logic [STEP_W-1:0] ST_GCHK   = 4'd5;
  localparam logic [STEP_W-1:0] ST_GFULL  = 4'd6;
  localparam logic [STEP_W-1:0] ST_SCAN   = 4'd7;
  localparam logic [STEP_W-1:0] ST_CLAIM  = 4'd8;
  localparam logic [STEP_W-1:0] ST_OUT    = 4'd9;
  localparam logic [STEP_W-1:0] ST_GOIDLE = 4'd10;
  localparam logic [STEP_W-1:0] ST_REL    = 4'd11;
  localparam logic [STEP_W-1:0] ST_FREE   = 4'd12;

  // control store: a taken condition jumps to target, otherwise next step
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] pc);
    ctrl_t w;
    case (pc)
      ST_IDLE:   w = '{op: OP_LOAD,    cond: COND_NO_INPUT,     target: ST_IDLE};
      ST_FUNC:   w = '{op: OP_CLRNEED, cond: COND_IS_REMOVE,    target: ST_REL};
      ST_DIV:    w = '{op: OP_DIVSTEP, cond: COND_DIV_MORE,     target: ST_DIV};
      ST_NEED:   w = '{op: OP_SETNEED, cond: COND_NEVER,        target: ST_IDLE};
      ST_CMP:    w = '{op: OP_NOP,     cond: COND_HELD_GE_NEED, target: ST_REL};
      ST_GCHK:   w = '{op: OP_NOP,     cond: COND_HELD_GE_NEED, target: ST_OUT};
      ST_GFULL:  w = '{op: OP_NOP,     cond: COND_HELD_FULL,    target: ST_OUT};
      ST_SCAN:   w = '{op: OP_ADVANCE, cond: COND_FRAME_BUSY,   target: ST_SCAN};
      ST_CLAIM:  w = '{op: OP_CLAIM,   cond: COND_FRAME_FREE,   target: ST_GCHK};
      ST_OUT:    w = '{op: OP_OUTPUT,  cond: COND_OUT_BLOCKED,  target: ST_OUT};
      ST_GOIDLE: w = '{op: OP_NOP,     cond: COND_ALWAYS,       target: ST_IDLE};
      ST_REL:    w = '{op: OP_RDMAP,   cond: COND_HELD_LE_NEED, target: ST_OUT};
      ST_FREE:   w = '{op: OP_FREE,    cond: COND_ALWAYS,       target: ST_REL};
      default:   w = '{op: OP_NOP,     cond: COND_ALWAYS,       target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/pfar_seq.sv @@
// ----------------------------------------------------------------------------
// pfar_seq
// step counter over the control store, with conditional jumps
// ----------------------------------------------------------------------------
module pfar_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  pfar_pkg::flags_t flags,
  output pfar_pkg::ctrl_t  ctrl
);

  logic [pfar_pkg::STEP_W-1:0] pc_r;
  logic [pfar_pkg::STEP_W-1:0] pc_nxt;
  logic                        take;

  assign ctrl = pfar_pkg::ucode(pc_r);

  always_comb begin
    case (ctrl.cond)
      pfar_pkg::COND_NEVER:        take = 1'b0;
      pfar_pkg::COND_ALWAYS:       take = 1'b1;
      pfar_pkg::COND_NO_INPUT:     take = flags.no_input;
      pfar_pkg::COND_IS_REMOVE:    take = flags.is_remove;
      pfar_pkg::COND_DIV_MORE:     take = flags.div_more;
      pfar_pkg::COND_HELD_GE_NEED: take = flags.held_ge_need;
      pfar_pkg::COND_HELD_LE_NEED: take = flags.held_le_need;
      pfar_pkg::COND_HELD_FULL:    take = flags.held_full;
      pfar_pkg::COND_FRAME_BUSY:   take = flags.frame_busy;
      pfar_pkg::COND_FRAME_FREE:   take = flags.frame_free;
      pfar_pkg::COND_OUT_BLOCKED:  take = flags.out_blocked;
      default:                     take = 1'b0;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + pfar_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= pfar_pkg::ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ hw/rtl/pfar_dp.sv @@
// ----------------------------------------------------------------------------
// pfar_dp
// allocator datapath: divider, frame scan, busy bits, page tables, result
// ----------------------------------------------------------------------------
module pfar_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pfar_pkg::ctrl_t                      ctrl,
  output pfar_pkg::flags_t                     flags,
  input  logic [pfar_pkg::PAGE_SIZE_W-1:0]     page_size,
  input  logic [pfar_pkg::FRAME_COUNT_W-1:0]   frame_count,
  input  logic                                 in_valid,
  input  logic                                 in_func,
  input  logic [pfar_pkg::SLOT_W-1:0]          in_process_slot,
  input  logic [pfar_pkg::BYTES_W-1:0]         in_new_size_bytes,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_status,
  output logic [pfar_pkg::CNT_W-1:0]           out_page_count
);

  localparam int PS_W = pfar_pkg::PAGE_SIZE_W;
  localparam int BW   = pfar_pkg::BYTES_W;
  localparam int CW   = pfar_pkg::CNT_W;
  localparam int FCW  = pfar_pkg::FRAME_COUNT_W;
  localparam int FW   = pfar_pkg::FRAME_W;
  localparam int PW   = pfar_pkg::PAGE_W;

  logic                          func_r;
  logic [pfar_pkg::SLOT_W-1:0]   slot_r;
  logic [BW-1:0]                 quo_r;
  logic [PS_W-1:0]               rem_r;
  logic [pfar_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [BW-1:0]                 need_r;
  logic [CW-1:0]                 held_r;
  logic [FCW-1:0]                ptr_r;
  logic [pfar_pkg::MAX_FRAMES-1:0] busy_r;
  logic [CW-1:0]                 pages_held_r [pfar_pkg::MAX_PROCESSES];
  logic [FW-1:0]                 map_mem [pfar_pkg::MAP_DEPTH];
  logic [FW-1:0]                 rd_frame_r;
  logic                          out_valid_r;
  logic                          out_status_r;
  logic [CW-1:0]                 out_page_count_r;

  logic [PS_W-1:0]               ps_eff;
  logic [PS_W:0]                 trial;
  logic [PS_W:0]                 diff;
  logic                          ge;
  logic [PS_W-1:0]               rem_nxt;
  logic [BW-1:0]                 quo_nxt;
  logic [BW-1:0]                 need_nxt;
  logic [BW-1:0]                 held_ext;
  logic [CW-1:0]                 held_dec;
  logic [FCW-1:0]                lim;
  logic                          scan_ok;
  logic                          cur_busy;
  logic                          out_blocked;
  logic [pfar_pkg::MAP_AW-1:0]   wr_addr;
  logic [pfar_pkg::MAP_AW-1:0]   rd_addr;

  // restoring division, one quotient bit per step
  always_comb begin
    ps_eff   = (page_size == '0) ? PS_W'(1) : page_size;
    trial    = {rem_r, quo_r[BW-1]};
    diff     = trial - {1'b0, ps_eff};
    ge       = trial >= {1'b0, ps_eff};
    rem_nxt  = ge ? diff[PS_W-1:0] : trial[PS_W-1:0];
    quo_nxt  = {quo_r[BW-2:0], ge};
    need_nxt = quo_r + BW'(rem_r != '0);
  end

  assign held_ext    = {{(BW - CW){1'b0}}, held_r};
  assign held_dec    = held_r - CW'(1);
  assign lim         = (frame_count > pfar_pkg::FRAME_LIMIT) ? pfar_pkg::FRAME_LIMIT : frame_count;
  assign scan_ok     = ptr_r < lim;
  assign cur_busy    = busy_r[ptr_r[FW-1:0]];
  assign out_blocked = out_valid_r && out_stall;
  assign wr_addr     = {slot_r, held_r[PW-1:0]};
  assign rd_addr     = {slot_r, held_dec[PW-1:0]};

  always_comb begin
    flags.no_input     = !in_valid;
    flags.is_remove    = func_r;
    flags.div_more     = div_cnt_r != pfar_pkg::DIV_CNT_W'(1);
    flags.held_ge_need = held_ext >= need_r;
    flags.held_le_need = held_ext <= need_r;
    flags.held_full    = held_r >= pfar_pkg::PAGES_LIMIT;
    flags.frame_busy   = scan_ok && cur_busy;
    flags.frame_free   = scan_ok && !cur_busy;
    flags.out_blocked  = out_blocked;
  end

  // busy bits, page counts and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= '0;
      pages_held_r <= '{default: '0};
      out_valid_r  <= 1'b0;
    end else begin
      case (ctrl.op)
        pfar_pkg::OP_CLAIM: begin
          if (scan_ok) begin
            busy_r[ptr_r[FW-1:0]] <= 1'b1;
          end
        end
        pfar_pkg::OP_FREE: begin
          busy_r[rd_frame_r] <= 1'b0;
        end
        pfar_pkg::OP_OUTPUT: begin
          pages_held_r[slot_r] <= held_r;
        end
        default: begin
        end
      endcase
      if (ctrl.op == pfar_pkg::OP_OUTPUT && !out_blocked) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk) begin
    case (ctrl.op)
      pfar_pkg::OP_LOAD: begin
        if (in_valid) begin
          func_r    <= in_func;
          slot_r    <= in_process_slot;
          quo_r     <= in_new_size_bytes;
          rem_r     <= '0;
          div_cnt_r <= pfar_pkg::DIV_STEPS;
          ptr_r     <= '0;
          held_r    <= pages_held_r[in_process_slot];
        end
      end
      pfar_pkg::OP_CLRNEED: begin
        need_r <= '0;
      end
      pfar_pkg::OP_DIVSTEP: begin
        quo_r     <= quo_nxt;
        rem_r     <= rem_nxt;
        div_cnt_r <= div_cnt_r - pfar_pkg::DIV_CNT_W'(1);
      end
      pfar_pkg::OP_SETNEED: begin
        need_r <= need_nxt;
      end
      pfar_pkg::OP_ADVANCE: begin
        if (scan_ok && cur_busy) begin
          ptr_r <= ptr_r + FCW'(1);
        end
      end
      pfar_pkg::OP_CLAIM: begin
        if (scan_ok) begin
          held_r <= held_r + CW'(1);
          ptr_r  <= ptr_r + FCW'(1);
        end
      end
      pfar_pkg::OP_FREE: begin
        held_r <= held_dec;
      end
      pfar_pkg::OP_OUTPUT: begin
        if (!out_blocked) begin
          // short of the target only when growth ran out
          out_status_r     <= held_ext < need_r;
          out_page_count_r <= held_r;
        end
      end
      default: begin
      end
    endcase
  end

  // page table store, registered read of the last page
  always_ff @(posedge clk) begin
    if (ctrl.op == pfar_pkg::OP_CLAIM && scan_ok) begin
      map_mem[wr_addr] <= ptr_r[FW-1:0];
    end
    rd_frame_r <= map_mem[rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_page_count = out_page_count_r;

endmodule

@@ hw/rtl/page_frame_allocator_resize_core.sv @@
// ----------------------------------------------------------------------------
// page_frame_allocator_resize_core: first fit frame allocator with resize
// resize: bytes divided into pages, frames claimed or last pages freed; remove: every page freed
// transactions: the next is taken only after the result of the last is registered
// reset: frames free, page counts zero, page_size 32, frame_count 64; no clearing pass
// ----------------------------------------------------------------------------
`include "page_frame_allocator_resize_core_macros.svh"

module page_frame_allocator_resize_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_func,
  input  logic [pfar_pkg::SLOT_W-1:0]          in_process_slot,
  input  logic [pfar_pkg::BYTES_W-1:0]         in_new_size_bytes,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_status,
  output logic [pfar_pkg::CNT_W-1:0]           out_page_count,
  input  logic                                 cfg_we,
  input  logic [pfar_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfar_pkg::CFG_W-1:0]           cfg_wdata
);

  logic [pfar_pkg::PAGE_SIZE_W-1:0]   page_size_r;
  logic [pfar_pkg::FRAME_COUNT_W-1:0] frame_count_r;
  pfar_pkg::ctrl_t                    ctrl;
  pfar_pkg::flags_t                   flags;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r   <= pfar_pkg::PAGE_SIZE_RST;
      frame_count_r <= pfar_pkg::FRAME_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pfar_pkg::REG_PAGE_SIZE:   page_size_r   <= cfg_wdata[pfar_pkg::PAGE_SIZE_W-1:0];
        pfar_pkg::REG_FRAME_COUNT: frame_count_r <= cfg_wdata[pfar_pkg::FRAME_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // only the idle step takes a transaction
  assign in_stall = !rst_n || (ctrl.op != pfar_pkg::OP_LOAD);

  pfar_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  pfar_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .flags             (flags),
    .page_size         (page_size_r),
    .frame_count       (frame_count_r),
    .in_valid          (in_valid),
    .in_func           (in_func),
    .in_process_slot   (in_process_slot),
    .in_new_size_bytes (in_new_size_bytes),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_page_count    (out_page_count)
  );

  `PFAR_ASSERT_NEXT(a_one_take_per_run, in_valid && !in_stall, in_stall, "transaction taken twice")
  `PFAR_ASSERT_SAME(a_count_bound, out_valid, out_page_count <= pfar_pkg::PAGES_LIMIT, "page count too big")
  `PFAR_ASSERT_SAME(a_result_from_ucode, $rose(out_valid), $past(ctrl.op == pfar_pkg::OP_OUTPUT), "stray result")

endmodule

@@ tb/page_frame_allocator_resize_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_frame_allocator_resize_core_test: self-checking bench for the allocator
// Drives resize and remove transactions through the request channel with
// random gaps and output back-pressure. A tracker keeps its own frame map,
// page tables and page counts and predicts the status and page count of
// every reply. Phases change page size and frame count, including zero and
// out-of-range settings.
// ----------------------------------------------------------------------------
module page_frame_allocator_resize_core_test;

  localparam logic FN_RESIZE = 1'b0;
  localparam logic FN_REMOVE = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_OOM    = 1'b1;

  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 250;

  typedef struct {
    logic                       status;
    logic [pfar_pkg::CNT_W-1:0] page_count;
  } alloc_reply_t;

  // tracks frames and page tables and holds the replies still owed
  class allocation_tracker;
    bit                             frame_busy [pfar_pkg::MAX_FRAMES];
    bit [pfar_pkg::FRAME_W-1:0]     page_map [pfar_pkg::MAX_PROCESSES][pfar_pkg::MAX_PAGES];
    bit [pfar_pkg::CNT_W-1:0]       pages_held [pfar_pkg::MAX_PROCESSES];
    bit [pfar_pkg::PAGE_SIZE_W-1:0] page_size;
    bit [pfar_pkg::FRAME_COUNT_W-1:0] frame_count;
    alloc_reply_t                   pending_replies[$];
    int errors, replies_seen, grows, shrinks, removes, oom_seen, reg_writes;

    function new();
      foreach (frame_busy[f]) frame_busy[f] = 1'b0;
      foreach (pages_held[s]) pages_held[s] = '0;
      page_size   = pfar_pkg::PAGE_SIZE_RST;
      frame_count = pfar_pkg::FRAME_COUNT_RST;
    endfunction

    function void set_reg(logic [pfar_pkg::CFG_IDX_W-1:0] idx,
                          logic [pfar_pkg::CFG_W-1:0] value);
      reg_writes++;
      if (idx == pfar_pkg::REG_PAGE_SIZE) page_size = value[pfar_pkg::PAGE_SIZE_W-1:0];
      else frame_count = value[pfar_pkg::FRAME_COUNT_W-1:0];
    endfunction

    function void free_down_to(int slot, int keep);
      while (pages_held[slot] > keep) begin
        pages_held[slot] = pages_held[slot] - 1'b1;
        frame_busy[page_map[slot][pages_held[slot]]] = 1'b0;
      end
    endfunction

    function void take_request(logic func, logic [pfar_pkg::SLOT_W-1:0] slot,
                               logic [pfar_pkg::BYTES_W-1:0] bytes);
      alloc_reply_t r;
      int ps, need, limit, fr;
      r.status = ST_OK;
      if (func == FN_REMOVE) begin
        removes++;
        free_down_to(slot, 0);
      end else begin
        ps    = (page_size == 0) ? 1 : int'(page_size);
        need  = int'(bytes) / ps + ((int'(bytes) % ps) != 0 ? 1 : 0);
        limit = (frame_count > pfar_pkg::MAX_FRAMES) ? pfar_pkg::MAX_FRAMES
                                                     : int'(frame_count);
        if (need > pages_held[slot]) begin
          grows++;
          while (pages_held[slot] < need) begin
            if (pages_held[slot] >= pfar_pkg::MAX_PAGES) begin
              r.status = ST_OOM;
              break;
            end
            // first fit: lowest free frame below the limit
            fr = -1;
            for (int f = 0; f < limit; f++) begin
              if (!frame_busy[f]) begin
                fr = f;
                break;
              end
            end
            if (fr < 0) begin
              r.status = ST_OOM;
              break;
            end
            frame_busy[fr] = 1'b1;
            page_map[slot][pages_held[slot]] = fr[pfar_pkg::FRAME_W-1:0];
            pages_held[slot] = pages_held[slot] + 1'b1;
          end
        end else begin
          shrinks++;
          free_down_to(slot, need);
        end
      end
      if (r.status == ST_OOM) oom_seen++;
      r.page_count = pages_held[slot];
      pending_replies.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic status, logic [pfar_pkg::CNT_W-1:0] page_count);
      alloc_reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply status %0d count %0d with nothing pending",
                                  status, page_count));
      end else begin
        want = pending_replies.pop_front();
        replies_seen++;
        if (status !== want.status)
          report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                    replies_seen, status, want.status));
        if (page_count !== want.page_count)
          report_mismatch($sformatf("reply %0d page_count %0d, want %0d",
                                    replies_seen, page_count, want.page_count));
      end
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             in_func = FN_RESIZE;
  logic [pfar_pkg::SLOT_W-1:0]      in_process_slot = '0;
  logic [pfar_pkg::BYTES_W-1:0]     in_new_size_bytes = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             out_status;
  logic [pfar_pkg::CNT_W-1:0]       out_page_count;
  logic                             cfg_we = 1'b0;
  logic [pfar_pkg::CFG_IDX_W-1:0]   cfg_index = pfar_pkg::REG_PAGE_SIZE;
  logic [pfar_pkg::CFG_W-1:0]       cfg_wdata = '0;

  allocation_tracker tracker = new();
  int gap_odds   = 0;
  int stall_odds = 0;

  page_frame_allocator_resize_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_process_slot   (in_process_slot),
    .in_new_size_bytes (in_new_size_bytes),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_page_count    (out_page_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (stall_odds != 0 && $urandom_range(stall_odds - 1) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(7, 1)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_status, out_page_count);
  end

  task automatic send_request(input logic func, input logic [pfar_pkg::SLOT_W-1:0] slot,
                              input logic [pfar_pkg::BYTES_W-1:0] bytes);
    if (gap_odds != 0 && $urandom_range(gap_odds - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= func;
    in_process_slot   <= slot;
    in_new_size_bytes <= bytes;
    do @(posedge clk); while (in_stall);
    tracker.take_request(func, slot, bytes);
  endtask

  // registers only change once the block has drained
  task automatic write_reg(input logic [pfar_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pfar_pkg::CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  initial begin
    int pick, pages, ps, sz;
    logic [pfar_pkg::SLOT_W-1:0]  slot;
    logic [pfar_pkg::BYTES_W-1:0] bytes;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset settings: page 32 bytes, 64 frames
    gap_odds   = 4;
    stall_odds = 4;
    send_request(FN_RESIZE, 4'd0, 20'd0);
    send_request(FN_RESIZE, 4'd0, 20'd1);
    send_request(FN_RESIZE, 4'd0, 20'd32);       // same page count
    send_request(FN_RESIZE, 4'd0, 20'd33);
    send_request(FN_RESIZE, 4'd15, 20'hFFFFF);   // runs out of frames
    send_request(FN_REMOVE, 4'd0, 20'hFFFFF);
    send_request(FN_RESIZE, 4'd3, 20'd2048);     // only two frames left
    send_request(FN_REMOVE, 4'd15, 20'd0);
    send_request(FN_REMOVE, 4'd15, 20'd0);       // slot already empty
    send_request(FN_RESIZE, 4'd3, 20'd2048);     // fills the page table
    send_request(FN_RESIZE, 4'd3, 20'd2049);     // beyond the page table
    send_request(FN_RESIZE, 4'd3, 20'd100);
    send_request(FN_REMOVE, 4'd3, 20'd0);
    // zero page size, zero frames
    write_reg(pfar_pkg::REG_PAGE_SIZE, '0);
    write_reg(pfar_pkg::REG_FRAME_COUNT, '0);
    send_request(FN_RESIZE, 4'd1, 20'd5);
    // frame count above the frame store
    write_reg(pfar_pkg::REG_FRAME_COUNT, pfar_pkg::CFG_W'(127));
    send_request(FN_RESIZE, 4'd1, 20'd5);
    send_request(FN_RESIZE, 4'd2, 20'd59);
    // frame count lowered under busy frames
    write_reg(pfar_pkg::REG_FRAME_COUNT, pfar_pkg::CFG_W'(8));
    send_request(FN_RESIZE, 4'd4, 20'd2);
    send_request(FN_REMOVE, 4'd2, 20'd0);
    send_request(FN_RESIZE, 4'd4, 20'd10);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(pfar_pkg::REG_PAGE_SIZE, pfar_pkg::CFG_W'(32));
          write_reg(pfar_pkg::REG_FRAME_COUNT, pfar_pkg::CFG_W'(64));
        end
        1: begin
          write_reg(pfar_pkg::REG_PAGE_SIZE, pfar_pkg::CFG_W'(1));
          write_reg(pfar_pkg::REG_FRAME_COUNT, pfar_pkg::CFG_W'(1));
        end
        2: begin
          write_reg(pfar_pkg::REG_PAGE_SIZE, pfar_pkg::CFG_W'(4096));
          write_reg(pfar_pkg::REG_FRAME_COUNT, pfar_pkg::CFG_W'(65));
        end
        3: begin
          write_reg(pfar_pkg::REG_PAGE_SIZE, '1);
          write_reg(pfar_pkg::REG_FRAME_COUNT, pfar_pkg::CFG_W'($urandom_range(63, 2)));
        end
        4: begin
          write_reg(pfar_pkg::REG_PAGE_SIZE, '0);
          write_reg(pfar_pkg::REG_FRAME_COUNT, '0);
        end
        5: begin
          write_reg(pfar_pkg::REG_PAGE_SIZE, pfar_pkg::CFG_W'($urandom_range(8191)));
          // upper bits of the data word lie outside the register
          write_reg(pfar_pkg::REG_FRAME_COUNT, {6'h3F, 7'd40});
        end
        6: begin
          write_reg(pfar_pkg::REG_PAGE_SIZE, pfar_pkg::CFG_W'($urandom_range(200, 2)));
          write_reg(pfar_pkg::REG_FRAME_COUNT, pfar_pkg::CFG_W'(127));
        end
        default: begin
          write_reg(pfar_pkg::REG_PAGE_SIZE, pfar_pkg::CFG_W'(32));
          write_reg(pfar_pkg::REG_FRAME_COUNT, pfar_pkg::CFG_W'(64));
        end
      endcase
      // last phase runs without gaps or back-pressure
      gap_odds   = (p == PHASES - 1) ? 0 : 2 << (p % 3);
      stall_odds = (p == PHASES - 1) ? 0 : 2 << ((p + 1) % 3);

      for (int n = 0; n < PHASE_REQS; n++) begin
        pick = $urandom_range(99);
        slot = pfar_pkg::SLOT_W'($urandom_range(pfar_pkg::MAX_PROCESSES - 1));
        ps   = (tracker.page_size == 0) ? 1 : int'(tracker.page_size);
        if (pick < 12) begin
          send_request(FN_REMOVE, slot, pfar_pkg::BYTES_W'($urandom));
        end else if (pick < 17) begin
          send_request(FN_RESIZE, slot, pfar_pkg::BYTES_W'($urandom));
        end else begin
          pages = (pick < 27) ? int'(tracker.pages_held[slot]) : $urandom_range(10);
          case ($urandom_range(3))
            0:       sz = pages * ps;
            1:       sz = pages * ps + 1;
            2:       sz = pages * ps - 1;
            default: sz = pages * ps + $urandom_range(ps - 1);
          endcase
          if (sz < 0) sz = 0;
          if (sz >= (1 << pfar_pkg::BYTES_W)) sz = (1 << pfar_pkg::BYTES_W) - 1;
          bytes = sz[pfar_pkg::BYTES_W-1:0];
          send_request(FN_RESIZE, slot, bytes);
        end
      end
    end

    in_valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d requests: %0d grow, %0d shrink or hold, %0d remove; %0d out of memory",
             tracker.grows + tracker.shrinks + tracker.removes, tracker.grows,
             tracker.shrinks, tracker.removes, tracker.oom_seen);
    $display("%0d replies checked over %0d register writes, %0d mismatches",
             tracker.replies_seen, tracker.reg_writes, tracker.errors);
    if (tracker.errors == 0 && tracker.pending_replies.size() == 0) begin
      $display("** page_frame_allocator_resize_core: PASSED **");
    end else begin
      $display("** page_frame_allocator_resize_core: FAILED **");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #40000000;
    $display("timeout with %0d replies outstanding", tracker.pending_replies.size());
    $display("** page_frame_allocator_resize_core: FAILED **");
    $finish;
  end

endmodule
